### rtl/r2fft_pkg.sv
// shared constants, types and helper functions for the radix-2 fft engine
// twiddle rom is built here at elaboration; no dependencies
`default_nettype none

package r2fft_pkg;

  localparam int MAX_LOG2_POINTS = 10;
  localparam int TWIDDLE_BITS    = 18;
  localparam int SAMPLE_BITS     = 16;
  localparam int STORE_BITS      = 28;

  localparam int ADDR_W  = MAX_LOG2_POINTS;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int BF_W    = MAX_LOG2_POINTS - 1;
  localparam int LOG_W   = 4;
  localparam int PADDR_W = 3;

  localparam int ROM_LOG     = (MAX_LOG2_POINTS < 2) ? 2 : MAX_LOG2_POINTS;
  localparam int ROM_QUARTER = 1 << (ROM_LOG - 2);
  localparam int ROM_IDX_W   = ROM_LOG - 1;
  localparam int KK_W        = ROM_LOG;

  localparam int PROD_W = STORE_BITS + TWIDDLE_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int T_W    = SUM_W - (TWIDDLE_BITS - 1);

  localparam logic [PADDR_W-1:0] ADDR_INVERSE = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] ADDR_LOG2    = PADDR_W'(4);

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_RUN  = 2'd1,
    REQ_READ = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB,
    ST_SC_RD,
    ST_SC_WR
  } state_e;

  typedef struct packed {
    logic signed [STORE_BITS-1:0] re;
    logic signed [STORE_BITS-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [TWIDDLE_BITS-1:0] re;
    logic signed [TWIDDLE_BITS-1:0] im;
  } tw_t;

  typedef logic signed [TWIDDLE_BITS-1:0] rom_t [ROM_QUARTER+1];

  function automatic logic signed [STORE_BITS-1:0] sat_store(input logic signed [T_W:0] v);
    logic [T_W-STORE_BITS+1:0] top;
    top = v[T_W:STORE_BITS-1];
    if (&top || ~|top) begin
      return v[STORE_BITS-1:0];
    end else if (v[T_W]) begin
      return {1'b1, {(STORE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STORE_BITS-1){1'b1}}};
    end
  endfunction

  // quarter-wave sine, taylor series in q2.30
  function automatic rom_t build_rom();
    rom_t r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint q;
    for (int k = 0; k <= ROM_QUARTER; k++) begin
      x = (64'd6746518853 * 64'(k) + (64'd1 << (ROM_LOG - 1))) >> ROM_LOG;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 3; n <= 17; n += 2) begin
        term = ((term * x2) >> 30) / 64'((n - 1) * n);
        if ((((n - 1) / 2) % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      q = (sum + (64'sd1 <<< (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
      if (q > ((64'sd1 <<< (TWIDDLE_BITS - 1)) - 1)) q = (64'sd1 <<< (TWIDDLE_BITS - 1)) - 1;
      r[k] = TWIDDLE_BITS'(q);
    end
    return r;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

endpackage

`default_nettype wire

### rtl/r2fft_req_if.sv
// request channel: valid/ready with load, run and read fields
// depends on r2fft_pkg
`default_nettype none

interface r2fft_req_if import r2fft_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [ADDR_W-1:0]             point_index;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (output valid, req_type, point_index, sample_real, sample_imag, input ready);
  modport sink (input valid, req_type, point_index, sample_real, sample_imag, output ready);
endinterface

`default_nettype wire

### rtl/r2fft_rsp_if.sv
// response channel: valid/ready with one result point
// depends on r2fft_pkg
`default_nettype none

interface r2fft_rsp_if import r2fft_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [STORE_BITS-1:0] result_real;
  logic signed [STORE_BITS-1:0] result_imag;
  logic [ADDR_W-1:0]            result_index;

  modport source (output valid, result_real, result_imag, result_index, input ready);
  modport sink (input valid, result_real, result_imag, result_index, output ready);
endinterface

`default_nettype wire

### rtl/radix2_fft_ifft_engine.sv
// load: one beat per cycle while idle, written at the bit-reversed address on acceptance
// read: result beat registered once the output is free, one read in flight
// run: each butterfly steps read a, read b, multiply, sum, write a, write b through
//   the shared butterfly unit and the store, plus a 1/N scaling pass when inverse
// reset clears sequencer and config (forward, L=10); point store is not cleared
`default_nettype none

module radix2_fft_ifft_engine import r2fft_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  r2fft_req_if.sink          req_i,
  r2fft_rsp_if.source        rsp_o
);

  state_e state_q, state_d;

  logic             inverse_q;
  logic [LOG_W-1:0] log2_q;
  logic [LOG_W-1:0] l_act;

  logic [LOG_W-1:0]  stage_q;
  logic [BF_W-1:0]   bf_q;
  logic [ADDR_W-1:0] sc_q;

  logic [ADDR_W-1:0] idx_mask, idx_m, rev_full, load_pos;
  logic [BF_W-1:0]   half_m1, j_off;
  logic [ADDR_W-1:0] a_addr, b_addr;
  logic              bf_last, stage_last;
  logic [KK_W-1:0]   kk;
  logic [ROM_IDX_W-1:0] idx_c, idx_s;
  logic              c_neg;
  logic signed [TWIDDLE_BITS-1:0] c_raw, s_raw;
  tw_t               tw_d, tw_q;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [2*STORE_BITS-1:0] ram_wdata, ram_rdata;
  cplx_t              dout, u_q, res_a, res_b, scaled;

  logic accept, out_free;
  logic rsp_valid_q;
  logic signed [STORE_BITS-1:0] rsp_re_q, rsp_im_q;
  logic [ADDR_W-1:0] rsp_idx_q, rd_idx_q;

  function automatic logic signed [STORE_BITS-1:0] scale_pt(
      input logic signed [STORE_BITS-1:0] v, input logic [LOG_W-1:0] l);
    logic signed [STORE_BITS:0] sv;
    sv = (STORE_BITS+1)'(v) + ((STORE_BITS+1)'(1) << (l - LOG_W'(1)));
    sv = sv >>> l;
    return sv[STORE_BITS-1:0];
  endfunction

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
      log2_q    <= LOG_W'(MAX_LOG2_POINTS);
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_INVERSE) inverse_q <= pwdata[0];
      if (paddr == ADDR_LOG2)    log2_q    <= pwdata[LOG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_INVERSE) prdata = {31'd0, inverse_q};
    if (paddr == ADDR_LOG2)    prdata = {{(32-LOG_W){1'b0}}, log2_q};
  end

  always_comb begin
    if (log2_q == '0) begin
      l_act = LOG_W'(1);
    end else if (log2_q > LOG_W'(MAX_LOG2_POINTS)) begin
      l_act = LOG_W'(MAX_LOG2_POINTS);
    end else begin
      l_act = log2_q;
    end
  end

  // index handling
  always_comb begin
    idx_mask = ADDR_W'(((ADDR_W+1)'(1) << l_act) - (ADDR_W+1)'(1));
    idx_m    = req_i.point_index & idx_mask;
    for (int b = 0; b < ADDR_W; b++) begin
      rev_full[b] = idx_m[ADDR_W-1-b];
    end
    load_pos = rev_full >> (LOG_W'(ADDR_W) - l_act);
  end

  // butterfly addressing and twiddle lookup
  always_comb begin
    half_m1    = BF_W'(((BF_W+1)'(1) << (stage_q - LOG_W'(1))) - (BF_W+1)'(1));
    j_off      = bf_q & half_m1;
    a_addr     = {bf_q & ~half_m1, 1'b0} | {1'b0, j_off};
    b_addr     = a_addr | (ADDR_W'(1) << (stage_q - LOG_W'(1)));
    bf_last    = (bf_q == idx_mask[ADDR_W-1:1]);
    stage_last = (stage_q == l_act);
    kk         = KK_W'(j_off) << (LOG_W'(ROM_LOG) - stage_q);
    if (kk <= KK_W'(ROM_QUARTER)) begin
      idx_c = ROM_IDX_W'(KK_W'(ROM_QUARTER) - kk);
      idx_s = ROM_IDX_W'(kk);
      c_neg = 1'b0;
    end else begin
      idx_c = ROM_IDX_W'(kk - KK_W'(ROM_QUARTER));
      idx_s = ROM_IDX_W'(KK_W'(ROM_QUARTER) - kk + KK_W'(ROM_QUARTER));
      c_neg = 1'b1;
    end
    c_raw   = SIN_ROM[idx_c];
    s_raw   = SIN_ROM[idx_s];
    tw_d.re = c_neg ? -c_raw : c_raw;
    tw_d.im = inverse_q ? s_raw : -s_raw;
  end

  always_ff @(posedge clk_i) begin
    tw_q <= tw_d;
    if (state_q == ST_BF_RB) u_q <= dout;
  end

  assign dout = cplx_t'(ram_rdata);

  r2fft_bfly u_bfly (
    .clk_i (clk_i),
    .u_i   (u_q),
    .b_i   (dout),
    .w_i   (tw_q),
    .a_o   (res_a),
    .b_o   (res_b)
  );

  assign scaled.re = scale_pt(dout.re, l_act);
  assign scaled.im = scale_pt(dout.im, l_act);

  r2fft_ram #(
    .WIDTH (2*STORE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_RUN:  state_d = ST_BF_RA;
            REQ_READ: state_d = ST_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD:     if (out_free) state_d = ST_IDLE;
      ST_BF_RA:  state_d = ST_BF_RB;
      ST_BF_RB:  state_d = ST_BF_MUL;
      ST_BF_MUL: state_d = ST_BF_SUM;
      ST_BF_SUM: state_d = ST_BF_WA;
      ST_BF_WA:  state_d = ST_BF_WB;
      ST_BF_WB: begin
        if (bf_last && stage_last) begin
          state_d = inverse_q ? ST_SC_RD : ST_IDLE;
        end else begin
          state_d = ST_BF_RA;
        end
      end
      ST_SC_RD:  state_d = ST_SC_WR;
      ST_SC_WR:  state_d = (sc_q == idx_mask) ? ST_IDLE : ST_SC_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = a_addr;
    ram_raddr = a_addr;
    ram_wdata = res_a;
    case (state_q)
      ST_IDLE: begin
        ram_we    = accept && (req_i.req_type == REQ_LOAD);
        ram_re    = accept && (req_i.req_type == REQ_READ);
        ram_waddr = load_pos;
        ram_raddr = idx_m;
        ram_wdata = {STORE_BITS'(req_i.sample_real), STORE_BITS'(req_i.sample_imag)};
      end
      ST_BF_RA: ram_re = 1'b1;
      ST_BF_RB: begin
        ram_re    = 1'b1;
        ram_raddr = b_addr;
      end
      ST_BF_WA: ram_we = 1'b1;
      ST_BF_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_addr;
        ram_wdata = res_b;
      end
      ST_SC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sc_q;
      end
      ST_SC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sc_q;
        ram_wdata = scaled;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= LOG_W'(1);
      bf_q    <= '0;
      sc_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          stage_q <= LOG_W'(1);
          bf_q    <= '0;
          sc_q    <= '0;
        end
        ST_BF_WB: begin
          if (bf_last) begin
            bf_q    <= '0;
            stage_q <= stage_q + LOG_W'(1);
          end else begin
            bf_q <= bf_q + BF_W'(1);
          end
        end
        ST_SC_WR: sc_q <= sc_q + ADDR_W'(1);
        default: ;
      endcase
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (accept) rd_idx_q <= idx_m;
    if ((state_q == ST_RD) && out_free) begin
      rsp_re_q  <= dout.re;
      rsp_im_q  <= dout.im;
      rsp_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((state_q == ST_RD) && out_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_real  = rsp_re_q;
  assign rsp_o.result_imag  = rsp_im_q;
  assign rsp_o.result_index = rsp_idx_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_i.ready)
    else $error("request accepted while busy");

  a_rsp_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_RD))
    else $error("result beat without read");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BF_RA) |-> (stage_q >= LOG_W'(1) && stage_q <= l_act))
    else $error("stage counter out of range");

  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BF_WB && bf_last && stage_last && !inverse_q) |=> (state_q == ST_IDLE))
    else $error("forward run did not finish after last butterfly");

endmodule

`default_nettype wire

### rtl/r2fft_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module r2fft_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/r2fft_bfly.sv
// two-stage butterfly unit: complex multiply, then round and saturating add/sub
// depends on r2fft_pkg
`default_nettype none

module r2fft_bfly import r2fft_pkg::*; (
  input  logic  clk_i,
  input  cplx_t u_i,
  input  cplx_t b_i,
  input  tw_t   w_i,
  output cplx_t a_o,
  output cplx_t b_o
);

  localparam logic signed [SUM_W-1:0] Rnd = SUM_W'(1) <<< (TWIDDLE_BITS - 2);

  logic signed [PROD_W-1:0] rr_q, ii_q, ri_q, ir_q;
  cplx_t                    u_q, a_q, bo_q;
  logic signed [SUM_W-1:0]  sum_re, sum_im;
  logic signed [T_W-1:0]    t_re, t_im;

  always_ff @(posedge clk_i) begin
    rr_q <= b_i.re * w_i.re;
    ii_q <= b_i.im * w_i.im;
    ri_q <= b_i.re * w_i.im;
    ir_q <= b_i.im * w_i.re;
    u_q  <= u_i;
  end

  always_comb begin
    sum_re = SUM_W'(rr_q) - SUM_W'(ii_q) + Rnd;
    sum_im = SUM_W'(ri_q) + SUM_W'(ir_q) + Rnd;
    t_re   = sum_re[SUM_W-1:TWIDDLE_BITS-1];
    t_im   = sum_im[SUM_W-1:TWIDDLE_BITS-1];
  end

  always_ff @(posedge clk_i) begin
    a_q.re  <= sat_store((T_W+1)'(u_q.re) + (T_W+1)'(t_re));
    a_q.im  <= sat_store((T_W+1)'(u_q.im) + (T_W+1)'(t_im));
    bo_q.re <= sat_store((T_W+1)'(u_q.re) - (T_W+1)'(t_re));
    bo_q.im <= sat_store((T_W+1)'(u_q.im) - (T_W+1)'(t_im));
  end

  assign a_o = a_q;
  assign b_o = bo_q;

endmodule

`default_nettype wire
